// ===== hdl/text_to_integer_parser_assert.svh =====
// Assertion helpers for the text-to-integer parser.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef TEXT_TO_INTEGER_PARSER_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_ASSERT_SVH

// Same-cycle implication.
`define TTIP_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ttip: same-cycle check failed");

// Next-cycle implication.
`define TTIP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ttip: next-cycle check failed");

`endif

// ===== hdl/ttip_pkg.sv =====
`default_nettype none

package ttip_pkg;

   localparam int BYTE_W   = 8;
   localparam int BASE_W   = 6;
   localparam int STATUS_W = 3;
   localparam int CLASS_W  = 6;

   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
   localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;

   // character classes above the digit values 0..35
   localparam logic [CLASS_W-1:0] CLS_SPACE = 6'd36;
   localparam logic [CLASS_W-1:0] CLS_OTHER = 6'd37;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGNED,
      PH_ZERO,
      PH_DIGITS,
      PH_TRAIL
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_BADBASE,
      ST_EMPTY,
      ST_NODIGITS,
      ST_BADCHAR,
      ST_RANGE,
      ST_OVERFLOW,
      ST_TRAILING
   } status_type;

   // digit value 0..35, or CLS_SPACE / CLS_OTHER
   function automatic logic [CLASS_W-1:0] classify(input logic [BYTE_W-1:0] c);
      logic [CLASS_W-1:0] k;
      k = CLS_OTHER;
      if (c inside {["0":"9"]}) begin
         k = CLASS_W'(c - 8'h30);
      end else if (c inside {["a":"z"]}) begin
         k = CLASS_W'(c - 8'h57);
      end else if (c inside {["A":"Z"]}) begin
         k = CLASS_W'(c - 8'h37);
      end else if (c inside {8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d}) begin
         k = CLS_SPACE;
      end
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ttip_if.sv =====
`default_nettype none

interface ttip_req_if import ttip_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_mark;

   modport source (output valid, output text_byte, output end_mark, input ready);
   modport sink   (input valid, input text_byte, input end_mark, output ready);
endinterface

interface ttip_rsp_if import ttip_pkg::*; #(parameter int RESULT_BITS = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [RESULT_BITS-1:0] value;
   logic [STATUS_W-1:0]           status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

interface ttip_csr_if import ttip_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BASE_W-1:0] radix;

   modport source (output valid, output radix, input ready);
   modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

// ===== hdl/text_to_integer_parser.sv =====
// Streaming text-to-integer parser.
// req_bus carries one character per transaction (text_byte) plus end_mark;
// a transaction with end_mark set, or with a zero text_byte, closes the
// string and produces exactly one rsp_bus transaction (value, status).
// All other transactions produce nothing on rsp_bus.
// csr_bus writes the radix register (0 = auto-detect from prefix, 2..36 =
// fixed base); it is always ready and should be written only while idle.
// The result of a closing transaction is registered and valid on rsp_bus
// in the cycle after acceptance. Throughput: one transaction per cycle
// while req_bus is ready; the per-character path is one multiply-add of
// the magnitude by a 6-bit base followed by the overflow compare, all combinational.
// The result sits in an output register; req_bus stays ready while that
// register is empty or being taken, so a stalled receiver blocks input
// only when a result is already waiting.
// Reset (synchronous, active high) clears the parse state, the radix
// register (back to auto-detect) and the output valid flag.
`default_nettype none
`include "text_to_integer_parser_assert.svh"

module text_to_integer_parser import ttip_pkg::*; #(
   parameter int RESULT_BITS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ttip_req_if.sink    req_bus,
   ttip_rsp_if.source  rsp_bus,
   ttip_csr_if.sink    csr_bus
);

   localparam int MAG_W  = RESULT_BITS - 1;
   // mag * 36 + 35 stays below 2^(MAG_W+6)
   localparam int PROD_W = MAG_W + BASE_W;

   // parse state
   phase_type         phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              seen_ff, seen_in;
   logic [BASE_W-1:0] base_ff, base_in;
   status_type        err_ff, err_in;
   logic [BASE_W-1:0] radix_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [RESULT_BITS-1:0] rsp_value_ff, rsp_value_in;
   status_type                    rsp_status_ff, rsp_status_in;

   logic               req_fire;
   logic               fin;
   logic               sample;
   logic [BASE_W-1:0]  eff_base;
   status_type         eff_err;
   logic [BASE_W-1:0]  dig_base;
   logic [CLASS_W-1:0] cls;
   logic [PROD_W-1:0]  prod;
   logic               ovf;
   logic [BYTE_W-1:0]  low_c;
   logic [BASE_W-1:0]  pbase;
   logic               zero_lead;
   logic               is_sign;

   // outcome of taking one digit character
   phase_type          d_phase;
   status_type         d_err;
   logic [MAG_W-1:0]   d_mag;
   logic               d_seen;

   status_type                    fin_status;
   logic signed [RESULT_BITS-1:0] mag_ext;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;

   assign fin = req_bus.end_mark || (req_bus.text_byte == '0);

   // radix is sampled on every transaction while still in leading whitespace
   assign sample   = (err_ff == ST_OK) && (phase_ff == PH_LEAD);
   assign eff_base = sample ? radix_ff : base_ff;
   assign eff_err  = (sample && ((radix_ff == BASE_ONE) || (radix_ff > BASE_MAX)))
                     ? ST_BADBASE : err_ff;

   // auto mode falls back to decimal once digits start
   assign dig_base = (eff_base == BASE_AUTO) ? BASE_DEC : eff_base;

   assign cls  = classify(req_bus.text_byte);
   assign prod = PROD_W'(mag_ff) * PROD_W'(dig_base) + PROD_W'(cls);
   assign ovf  = |prod[PROD_W-1:MAG_W];

   assign low_c     = req_bus.text_byte | 8'h20;
   assign is_sign   = (req_bus.text_byte == "-") || (req_bus.text_byte == "+");
   assign zero_lead = (req_bus.text_byte == "0") &&
                      (eff_base inside {BASE_AUTO, BASE_HEX, BASE_BIN, BASE_OCT});

   always_comb begin
      case (low_c)
         "x":     pbase = BASE_HEX;
         "b":     pbase = BASE_BIN;
         "o":     pbase = BASE_OCT;
         default: pbase = BASE_AUTO;
      endcase
   end

   // digit step: whitespace ends the number, else bad-character, range and overflow checks
   always_comb begin
      d_phase = PH_DIGITS;
      d_err   = ST_OK;
      d_mag   = mag_ff;
      d_seen  = seen_ff;
      if (cls == CLS_SPACE) begin
         d_phase = PH_TRAIL;
      end else if (cls == CLS_OTHER) begin
         d_err = ST_BADCHAR;
      end else if (cls >= dig_base) begin
         d_err = seen_ff ? ST_TRAILING : ST_RANGE;
      end else if (ovf) begin
         d_err = ST_OVERFLOW;
      end else begin
         d_mag  = prod[MAG_W-1:0];
         d_seen = 1'b1;
      end
   end

   // next state; radix sampling only happens on an accepted transaction
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      seen_in  = seen_ff;
      base_in  = base_ff;
      err_in   = err_ff;
      if (req_fire) begin
         base_in = eff_base;
         err_in  = eff_err;
         if (fin) begin
            phase_in = PH_LEAD;
            neg_in   = 1'b0;
            mag_in   = '0;
            seen_in  = 1'b0;
            base_in  = BASE_AUTO;
            err_in   = ST_OK;
         end else if (eff_err == ST_OK) begin
            case (phase_ff)
               PH_LEAD, PH_SIGNED: begin
                  if (phase_ff == PH_LEAD && cls == CLS_SPACE) begin
                     phase_in = PH_LEAD;
                  end else if (phase_ff == PH_LEAD && is_sign) begin
                     neg_in   = (req_bus.text_byte == "-");
                     phase_in = PH_SIGNED;
                  end else if (zero_lead) begin
                     phase_in = PH_ZERO;
                     seen_in  = 1'b1;
                     mag_in   = '0;
                  end else begin
                     base_in  = dig_base;
                     phase_in = d_phase;
                     err_in   = d_err;
                     mag_in   = d_mag;
                     seen_in  = d_seen;
                  end
               end
               PH_ZERO: begin
                  if (pbase != BASE_AUTO &&
                      (eff_base == BASE_AUTO || eff_base == pbase)) begin
                     base_in  = pbase;
                     seen_in  = 1'b0;
                     phase_in = PH_DIGITS;
                  end else begin
                     base_in  = dig_base;
                     phase_in = d_phase;
                     err_in   = d_err;
                     mag_in   = d_mag;
                     seen_in  = d_seen;
                  end
               end
               PH_DIGITS: begin
                  phase_in = d_phase;
                  err_in   = d_err;
                  mag_in   = d_mag;
                  seen_in  = d_seen;
               end
               PH_TRAIL: begin
                  if (cls != CLS_SPACE) begin
                     err_in = ST_TRAILING;
                  end
               end
               default: begin
                  phase_in = PH_LEAD;
               end
            endcase
         end
      end
   end

   // result on the closing transaction
   assign mag_ext = RESULT_BITS'(mag_ff);

   always_comb begin
      if (eff_err != ST_OK) begin
         fin_status = eff_err;
      end else if (phase_ff == PH_LEAD) begin
         fin_status = ST_EMPTY;
      end else if (!seen_ff) begin
         fin_status = ST_NODIGITS;
      end else begin
         fin_status = ST_OK;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (req_fire && fin) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         if (fin_status == ST_OK) begin
            rsp_value_in = neg_ff ? -mag_ext : mag_ext;
         end else begin
            rsp_value_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         seen_ff      <= 1'b0;
         base_ff      <= BASE_AUTO;
         err_ff       <= ST_OK;
         radix_ff     <= BASE_AUTO;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         seen_ff      <= seen_in;
         base_ff      <= base_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            radix_ff <= csr_bus.radix;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // failed parses always report a zero value
   `TTIP_ASSERT_IMPL(a_err_value_zero, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_value_ff == '0)
   // magnitude only grows after a digit has been taken
   `TTIP_ASSERT_IMPL(a_mag_needs_digit, !seen_ff, mag_ff == '0)
   // closing transaction yields a result and a fresh parse state
   `TTIP_ASSERT_NEXT(a_fin_result, req_fire && fin, rsp_valid_ff && phase_ff == PH_LEAD && !seen_ff)
   // ordinary characters never create a result
   `TTIP_ASSERT_NEXT(a_no_spurious, req_fire && !fin && !rsp_valid_ff, !rsp_valid_ff)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   import ttip_pkg::*;

   localparam int VALUE_BITS = 32;
   localparam int SPACE_KIND = 36;             // char class: ASCII whitespace
   localparam int JUNK_KIND  = 37;             // char class: anything else
   localparam longint unsigned MAG_LIMIT = 64'h7fff_ffff;
   localparam int RANDOM_TARGET = 1300;

   // one expected rsp transaction
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      status_type            status;
   } parsed_t;

   // Predicts each string's outcome as bytes are accepted and holds the
   // results still owed by the block, oldest first.
   class parse_ledger;
      phase_type   step;
      bit          minus;
      bit [30:0]   mag;
      bit          have_digit;
      bit [5:0]    base;
      status_type  fault;
      bit [5:0]    radix;
      parsed_t     awaited[$];
      int          errors;

      function new();
         radix  = BASE_AUTO;
         errors = 0;
         restart();
      endfunction

      function void restart();
         step       = PH_LEAD;
         minus      = 1'b0;
         mag        = '0;
         have_digit = 1'b0;
         base       = BASE_AUTO;
         fault      = ST_OK;
      endfunction

      function void load_radix(logic [5:0] r);
         radix = r;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function int char_kind(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - int'("0");
         if (c >= "a" && c <= "z") return int'(c) - int'("a") + 10;
         if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
         if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0d)) return SPACE_KIND;
         return JUNK_KIND;
      endfunction

      function void add_digit(logic [7:0] c);
         int k;
         longint unsigned wide;
         k = char_kind(c);
         if (k == SPACE_KIND) begin
            step = PH_TRAIL;
         end else if (k == JUNK_KIND) begin
            fault = ST_BADCHAR;
         end else if (k >= int'(base)) begin
            // out-of-range digit after real digits reads as trailing junk
            if (have_digit) fault = ST_TRAILING;
            else fault = ST_RANGE;
         end else begin
            wide = 64'(mag) * 64'(base) + 64'(k);
            if (base == 0 || wide > MAG_LIMIT) begin
               fault = ST_OVERFLOW;
            end else begin
               mag        = wide[30:0];
               have_digit = 1'b1;
            end
         end
      endfunction

      function void begin_number(logic [7:0] c);
         if (c == "0" && (base == BASE_AUTO || base == BASE_HEX ||
                          base == BASE_BIN || base == BASE_OCT)) begin
            step       = PH_ZERO;   // lone zero unless a prefix letter follows
            have_digit = 1'b1;
            mag        = '0;
         end else begin
            if (base == BASE_AUTO) base = BASE_DEC;
            step = PH_DIGITS;
            add_digit(c);
         end
      endfunction

      function void after_zero(logic [7:0] c);
         logic [7:0] lc;
         logic [5:0] pb;
         lc = c | 8'h20;
         pb = BASE_AUTO;
         if (lc == "x") pb = BASE_HEX;
         else if (lc == "b") pb = BASE_BIN;
         else if (lc == "o") pb = BASE_OCT;
         if (pb != BASE_AUTO && (base == BASE_AUTO || base == pb)) begin
            base       = pb;
            have_digit = 1'b0;
            step       = PH_DIGITS;
         end else begin
            if (base == BASE_AUTO) base = BASE_DEC;
            step = PH_DIGITS;
            add_digit(c);
         end
      endfunction

      function void note_input(logic [7:0] c, logic mark);
         parsed_t r;
         // radix is sampled on every transaction while still in leading space
         if (fault == ST_OK && step == PH_LEAD) begin
            base = radix;
            if (radix == BASE_ONE || radix > BASE_MAX) fault = ST_BADBASE;
         end
         if (mark || c == 8'h00) begin
            r.status = fault;
            r.value  = '0;
            if (fault == ST_OK) begin
               if (step == PH_LEAD) r.status = ST_EMPTY;
               else if (!have_digit) r.status = ST_NODIGITS;
               else if (minus) r.value = VALUE_BITS'(0) - VALUE_BITS'(mag);
               else r.value = VALUE_BITS'(mag);
            end
            awaited.push_back(r);
            restart();
            return;
         end
         if (fault != ST_OK) return;
         case (step)
            PH_LEAD: begin
               if (char_kind(c) != SPACE_KIND) begin
                  if (c == "-" || c == "+") begin
                     minus = (c == "-");
                     step  = PH_SIGNED;
                  end else begin
                     begin_number(c);
                  end
               end
            end
            PH_SIGNED: begin_number(c);
            PH_ZERO:   after_zero(c);
            PH_DIGITS: add_digit(c);
            default: begin
               if (char_kind(c) != SPACE_KIND) fault = ST_TRAILING;
            end
         endcase
      endfunction

      task report(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      task check_result(logic signed [VALUE_BITS-1:0] v, logic [STATUS_W-1:0] s);
         parsed_t e;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result value=%0d status=%0d", v, s));
            return;
         end
         e = awaited.pop_front();
         if (v !== $signed(e.value))
            report($sformatf("value %0d, want %0d", v, $signed(e.value)));
         if (s !== e.status)
            report($sformatf("status %0d, want %0d", s, e.status));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ttip_req_if                             req_bus ();
   ttip_rsp_if #(.RESULT_BITS(VALUE_BITS)) rsp_bus ();
   ttip_csr_if                             csr_bus ();

   text_to_integer_parser #(.RESULT_BITS(VALUE_BITS)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   parse_ledger ledger = new();

   // sender / receiver pacing
   int         burst_left    = 0;
   bit         gaps_on       = 1'b1;
   int         hold_request  = 0;
   int         hold_left     = 0;
   int unsigned stall_tick   = 0;
   int         items_sent    = 0;
   int         random_items  = 0;
   bit         counting      = 1'b0;
   logic [5:0] cur_radix     = BASE_AUTO;
   logic [7:0] text_q[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop. Slowest legal run is well under a tenth of this.
   initial begin
      #1000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: changes ready on the falling edge. A long hold-off request
   // wins; otherwise the pattern rotates, stepped by a tick counter, through always
   // ready, coin flip, mostly stalled and mostly ready.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready = 1'b0;
      end else begin
         stall_tick++;
         case (stall_tick[7:6])
            2'd0: rsp_bus.ready = 1'b1;
            2'd1: rsp_bus.ready = 1'($urandom_range(0, 1));
            2'd2: rsp_bus.ready = ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Result side: every rsp transaction goes against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         ledger.check_result(rsp_bus.value, rsp_bus.status);
   end

   // One req transaction. Bursts of random length, random gaps between
   // bursts unless gaps are switched off for a pressure run.
   task automatic send_byte(input logic [7:0] b, input logic mark);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.text_byte = b;
      req_bus.end_mark  = mark;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      ledger.note_input(b, mark);
      items_sent++;
      if (counting) random_items++;
   endtask

   // Sends text_q and closes it either with a zero byte or with end_mark
   // (the byte riding along with end_mark is random and must be ignored).
   task automatic send_text(input bit zero_end);
      foreach (text_q[i]) send_byte(text_q[i], 1'b0);
      if (zero_end) send_byte(8'h00, 1'b0);
      else send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_str(input string s, input bit zero_end = 1'b0);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_text(zero_end);
   endtask

   // Stop offering input until every outstanding result is back.
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
   endtask

   // Radix only changes with the parser idle, after a drain.
   task automatic write_radix(input logic [5:0] r);
      drain();
      repeat (4) @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.radix = r;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      ledger.load_radix(r);
      cur_radix = r;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   function automatic logic [7:0] digit_char(int d);
      logic [7:0] c;
      if (d < 10) begin
         c = 8'(int'("0") + d);
      end else begin
         c = 8'(int'("a") + d - 10);
         if ($urandom_range(0, 1)) c = c - 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] blank();
      int k;
      k = $urandom_range(0, 5);
      return (k == 0) ? 8'h20 : 8'(8 + k);
   endfunction

   task automatic push_number(input longint unsigned val, input int b);
      logic [7:0] rev[$];
      longint unsigned bb;
      bb = longint'(b);
      do begin
         rev.push_front(digit_char(int'(val % bb)));
         val = val / bb;
      end while (val != 0);
      foreach (rev[i]) text_q.push_back(rev[i]);
   endtask

   // Mostly well-formed numerals with random content: optional space, sign,
   // prefix, digits (some right at the 31-bit limit), optional junk and tail.
   // About one in eight strings is raw byte noise.
   task automatic random_line();
      int pick;
      int eb;
      int sel;
      longint unsigned val;
      logic [7:0] letter;
      text_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_q.push_back(blank());
         sel = $urandom_range(0, 3);
         if (sel == 0) text_q.push_back("+");
         else if (sel == 1) text_q.push_back("-");
         eb = (cur_radix >= BASE_BIN && cur_radix <= BASE_MAX) ? int'(cur_radix)
                                                                 : int'(BASE_DEC);
         if ((cur_radix == BASE_AUTO || cur_radix == BASE_HEX || cur_radix == BASE_BIN ||
              cur_radix == BASE_OCT) && $urandom_range(0, 2) == 0) begin
            sel = $urandom_range(0, 2);
            if (cur_radix == BASE_HEX || (cur_radix == BASE_AUTO && sel == 0)) begin
               letter = "x";
               eb     = BASE_HEX;
            end else if (cur_radix == BASE_BIN || (cur_radix == BASE_AUTO && sel == 1)) begin
               letter = "b";
               eb     = BASE_BIN;
            end else begin
               letter = "o";
               eb     = BASE_OCT;
            end
            text_q.push_back("0");
            text_q.push_back($urandom_range(0, 1) ? letter - 8'h20 : letter);
         end
         sel = $urandom_range(0, 9);
         if (sel == 1) begin
            // land on and around the overflow boundary
            case ($urandom_range(0, 4))
               0: val = 64'h7fff_ffff;
               1: val = 64'h8000_0000;
               2: val = 64'h7fff_fffe;
               3: val = {$urandom, $urandom} >> $urandom_range(0, 63);
               default: val = $urandom_range(0, 1000);
            endcase
            push_number(val, eb);
         end else if (sel != 0) begin
            repeat ($urandom_range(1, 7))
               text_q.push_back(digit_char($urandom_range(0, eb - 1)));
         end
         if ($urandom_range(0, 9) == 0)
            text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(1, 255)));
         if ($urandom_range(0, 6) == 0) begin
            text_q.push_back(blank());
            if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(1, 255)));
         end
      end
      send_text($urandom_range(0, 4) == 0);
   endtask

   // Receiver goes dark for a long stretch while the sender streams short
   // strings back to back: the output register fills and req stalls.
   task automatic hold_burst();
      gaps_on      = 1'b0;
      hold_request = 64;
      repeat (40) begin
         text_q.delete();
         text_q.push_back(8'(int'("1") + $urandom_range(0, 8)));
         send_text(1'b0);
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      logic [5:0] plan[$];
      logic [5:0] r;
      int idx;
      int phase_start;
      int phase_len;

      plan = '{BASE_DEC, BASE_AUTO, BASE_HEX, BASE_BIN, BASE_OCT, BASE_MAX,
               6'd37, 6'd63, BASE_ONE};
      req_bus.valid     = 1'b0;
      req_bus.text_byte = 8'h00;
      req_bus.end_mark  = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.radix     = BASE_AUTO;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: auto-detect
      write_radix(BASE_AUTO);
      send_str("");                          // nothing at all -> empty
      send_str(" \011\012\013\014\015");     // whitespace only -> empty
      send_str("-");                         // sign alone -> no digits
      send_str("0x \011");                   // space right after prefix
      send_str("0");                         // lone zero
      send_str("-07");
      send_str("2147483647");
      send_str("-2147483648");               // one past the magnitude limit
      send_str("12a");                       // range digit after digits
      send_str("a");                         // range digit first
      send_str("--1");                       // second sign
      send_str("12 3");                      // junk after trailing space
      send_str("12  ");
      send_str("0X1F");
      send_str("0b101");
      send_str("0B2");
      send_str("\377");
      send_str("42", 1'b1);                  // zero byte closes the string
      // directed: fixed bases and bad bases
      write_radix(BASE_HEX);
      send_str("0x7FfFfFfF");
      send_str("0b1");                       // 'b' is a hex digit here
      write_radix(BASE_MAX);
      send_str("zik0zj");
      send_str("-zik0zk");
      write_radix(BASE_ONE);
      send_str("5");
      write_radix(6'd63);
      send_str("");

      // random phases across radix settings
      idx = 0;
      while (random_items < RANDOM_TARGET) begin
         if (idx < plan.size()) begin
            r = plan[idx];
         end else begin
            case ($urandom_range(0, 9))
               0: r = BASE_AUTO;
               1: r = 6'($urandom_range(37, 63));
               default: r = 6'($urandom_range(2, 36));
            endcase
         end
         write_radix(r);
         // bad radix: every byte is ignored, keep those phases short
         counting  = (r != BASE_ONE && r <= BASE_MAX);
         phase_len = counting ? 90 : 30;
         phase_start = items_sent;
         if (idx == 1 || idx == 5) hold_burst();
         while (items_sent - phase_start < phase_len) random_line();
         counting = 1'b0;
         idx++;
      end

      drain();
      repeat (8) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/ttip_pkg.sv
hdl/ttip_if.sv
hdl/text_to_integer_parser.sv
tb/tb.sv
